@@ src/vec4_move_towards_top_assert.svh @@
// Assertion macros shared by the RTL.
`ifndef VEC4_MOVE_TOWARDS_TOP_ASSERT_SVH
`define VEC4_MOVE_TOWARDS_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define VMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define VMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/vmt_pkg.sv @@
`timescale 1ns / 1ps
package vmt_pkg;
  localparam int COMP_WIDTH_DEF = 32;
endpackage

@@ src/vmt_front.sv @@
`timescale 1ns / 1ps
module vmt_front #(
  parameter int W = vmt_pkg::COMP_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic [4*W-1:0]       cur_in,
  input  logic [4*W-1:0]       goal_in,
  input  logic [W-1:0]         step_in,
  output logic                 valid,
  output logic [2*W+2:0]       sq_sum,
  output logic                 reached,
  output logic [4*(2*W+1)-1:0] num,
  output logic [4*W-1:0]       cur,
  output logic [4*W-1:0]       goal,
  output logic [3:0]           neg
);
  import vmt_pkg::*;

  localparam int NW = 2 * W + 1;

  // stage 1: capture word
  logic           v1;
  logic [4*W-1:0] c1, g1;
  logic [W-1:0]   s1;
  // stage 2: differences
  logic           v2;
  logic [W:0]     d2 [4];
  logic [4*W-1:0] c2, g2;
  logic [W-1:0]   s2;
  // stage 3: products
  logic           v3;
  logic [2*W+1:0] sq3 [4];
  logic [NW-1:0]  ds3 [4];
  logic [2*W-1:0] ssq3;
  logic           sneg3;
  logic [3:0]     neg3;
  logic [4*W-1:0] c3, g3;
  // stage 4: pair sums
  logic           v4;
  logic [2*W+2:0] s01, s23;
  logic [2*W-1:0] ssq4;
  logic           sneg4;
  logic [3:0]     neg4;
  logic [4*NW-1:0] ds4;
  logic [4*W-1:0] c4, g4;
  // stage 5: total
  logic           v5;
  logic [2*W+2:0] tot5;
  logic [2*W-1:0] ssq5;
  logic           sneg5;
  logic [3:0]     neg5;
  logic [4*NW-1:0] ds5;
  logic [4*W-1:0] c5, g5;

  logic [W:0]     dmag [4];
  logic [W-1:0]   smag;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dmag[i] = d2[i][W] ? (~d2[i] + 1'b1) : d2[i];
    end
    smag = s2[W-1] ? (~s2 + 1'b1) : s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= cur_in;
      g1 <= goal_in;
      s1 <= step_in;

      for (int i = 0; i < 4; i++) begin
        d2[i] <= {g1[i*W+W-1], g1[i*W +: W]} - {c1[i*W+W-1], c1[i*W +: W]};
      end
      c2 <= c1;
      g2 <= g1;
      s2 <= s1;

      for (int i = 0; i < 4; i++) begin
        sq3[i]  <= dmag[i] * dmag[i];
        ds3[i]  <= dmag[i] * smag;
        neg3[i] <= d2[i][W] ^ s2[W-1];
      end
      ssq3  <= smag * smag;
      sneg3 <= s2[W-1];
      c3 <= c2;
      g3 <= g2;

      s01   <= {1'b0, sq3[0]} + {1'b0, sq3[1]};
      s23   <= {1'b0, sq3[2]} + {1'b0, sq3[3]};
      ssq4  <= ssq3;
      sneg4 <= sneg3;
      neg4  <= neg3;
      ds4   <= {ds3[3], ds3[2], ds3[1], ds3[0]};
      c4 <= c3;
      g4 <= g3;

      tot5  <= s01 + s23;
      ssq5  <= ssq4;
      sneg5 <= sneg4;
      neg5  <= neg4;
      ds5   <= ds4;
      c5 <= c4;
      g5 <= g4;

      sq_sum  <= tot5;
      reached <= (tot5 == '0) || (!sneg5 && (tot5 <= {3'b000, ssq5}));
      neg     <= neg5;
      num     <= ds5;
      cur     <= c5;
      goal    <= g5;
    end
  end
endmodule

@@ src/vmt_sqrt_cell.sv @@
`timescale 1ns / 1ps
module vmt_sqrt_cell #(
  parameter int N  = vmt_pkg::COMP_WIDTH_DEF + 2,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            valid_in,
  input  logic [2*N-1:0]  rad_in,
  input  logic [N+1:0]    rem_in,
  input  logic [N-1:0]    root_in,
  input  logic [PW-1:0]   pass_in,
  output logic            valid,
  output logic [2*N-1:0]  rad,
  output logic [N+1:0]    rem,
  output logic [N-1:0]    root,
  output logic [PW-1:0]   pass
);
  import vmt_pkg::*;

  logic [N+1:0] rsh, trial, diff;
  logic         ge;

  always_comb begin
    rsh   = {rem_in[N-1:0], rad_in[2*N-1:2*N-2]};
    trial = {root_in, 2'b01};
    ge    = rsh >= trial;
    diff  = rsh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad  <= {rad_in[2*N-3:0], 2'b00};
      rem  <= ge ? diff : rsh;
      root <= {root_in[N-2:0], ge};
      pass <= pass_in;
    end
  end
endmodule

@@ src/vmt_div_cell.sv @@
`timescale 1ns / 1ps
module vmt_div_cell #(
  parameter int W  = vmt_pkg::COMP_WIDTH_DEF,
  parameter int PW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  logic [W+1:0]      len_in,
  input  logic [4*(W+3)-1:0] rem_in,
  input  logic [4*W-1:0]    low_in,
  input  logic [4*W-1:0]    quo_in,
  input  logic [PW-1:0]     pass_in,
  output logic              valid,
  output logic [W+1:0]      len,
  output logic [4*(W+3)-1:0] rem,
  output logic [4*W-1:0]    low,
  output logic [4*W-1:0]    quo,
  output logic [PW-1:0]     pass
);
  import vmt_pkg::*;

  logic [W+2:0] rsh  [4];
  logic [W+2:0] diff [4];
  logic [3:0]   ge;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rsh[i]  = {rem_in[i*(W+3) +: W+2], low_in[i*W+W-1]};
      ge[i]   = rsh[i] >= {1'b0, len_in};
      diff[i] = rsh[i] - {1'b0, len_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len  <= len_in;
      pass <= pass_in;
      for (int i = 0; i < 4; i++) begin
        rem[i*(W+3) +: W+3] <= ge[i] ? diff[i] : rsh[i];
        low[i*W +: W]       <= {low_in[i*W +: W-1], 1'b0};
        quo[i*W +: W]       <= {quo_in[i*W +: W-1], ge[i]};
      end
    end
  end
endmodule

@@ src/vec4_move_towards_top.sv @@
`timescale 1ns / 1ps
// Moves a 4-component signed fixed-point point toward a goal by at most
// step_max, saturating each component. One word is accepted per cycle
// while no result waits at the output, and results leave in order through
// six front stages for differences, products and the length compare,
// COMP_WIDTH+2 square-root cells producing one root bit each, COMP_WIDTH
// divider cells producing one quotient bit per component each, and one
// output stage. The whole chain holds while a result waits.
`include "vec4_move_towards_top_assert.svh"
module vec4_move_towards_top #(
  parameter int COMP_WIDTH = vmt_pkg::COMP_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COMP_WIDTH-1:0] cur_x,
  input  logic signed [COMP_WIDTH-1:0] cur_y,
  input  logic signed [COMP_WIDTH-1:0] cur_z,
  input  logic signed [COMP_WIDTH-1:0] cur_w,
  input  logic signed [COMP_WIDTH-1:0] goal_x,
  input  logic signed [COMP_WIDTH-1:0] goal_y,
  input  logic signed [COMP_WIDTH-1:0] goal_z,
  input  logic signed [COMP_WIDTH-1:0] goal_w,
  input  logic signed [COMP_WIDTH-1:0] step_max,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COMP_WIDTH-1:0] next_x,
  output logic signed [COMP_WIDTH-1:0] next_y,
  output logic signed [COMP_WIDTH-1:0] next_z,
  output logic signed [COMP_WIDTH-1:0] next_w,
  output logic                         reached
);
  import vmt_pkg::*;

  localparam int W   = COMP_WIDTH;
  localparam int N   = W + 2;
  localparam int NW  = 2 * W + 1;
  localparam int PW2 = 8 * W + 5;
  localparam int PW  = 4 * NW + PW2;

  logic en;

  logic                f_valid;
  logic [2*W+2:0]      f_sum;
  logic                f_reached;
  logic [4*NW-1:0]     f_num;
  logic [4*W-1:0]      f_cur, f_goal;
  logic [3:0]          f_neg;

  logic            sv   [0:N];
  logic [2*N-1:0]  srad [0:N];
  logic [N+1:0]    srem [0:N];
  logic [N-1:0]    sroot[0:N];
  logic [PW-1:0]   spass[0:N];

  logic               dv   [0:W];
  logic [N-1:0]       dlen [0:W];
  logic [4*(W+3)-1:0] drem [0:W];
  logic [4*W-1:0]     dlow [0:W];
  logic [4*W-1:0]     dquo [0:W];
  logic [PW2-1:0]     dpass[0:W];

  logic [4*W-1:0] e_cur, e_goal;
  logic [3:0]     e_neg;
  logic           e_reached;
  logic [W-1:0]   res [4];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  vmt_front #(.W(W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (in_valid),
    .cur_in   ({cur_w, cur_z, cur_y, cur_x}),
    .goal_in  ({goal_w, goal_z, goal_y, goal_x}),
    .step_in  (step_max),
    .valid    (f_valid),
    .sq_sum   (f_sum),
    .reached  (f_reached),
    .num      (f_num),
    .cur      (f_cur),
    .goal     (f_goal),
    .neg      (f_neg)
  );

  assign sv[0]    = f_valid;
  assign srad[0]  = {1'b0, f_sum};
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign spass[0] = {f_num, f_cur, f_goal, f_neg, f_reached};

  for (genvar k = 0; k < N; k++) begin : g_sqrt
    vmt_sqrt_cell #(.N(N), .PW(PW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (sv[k]),
      .rad_in   (srad[k]),
      .rem_in   (srem[k]),
      .root_in  (sroot[k]),
      .pass_in  (spass[k]),
      .valid    (sv[k+1]),
      .rad      (srad[k+1]),
      .rem      (srem[k+1]),
      .root     (sroot[k+1]),
      .pass     (spass[k+1])
    );
  end

  assign dv[0]    = sv[N];
  assign dlen[0]  = sroot[N];
  assign dpass[0] = spass[N][PW2-1:0];
  for (genvar i = 0; i < 4; i++) begin : g_seed
    assign drem[0][i*(W+3) +: W+3] = {2'b00, spass[N][PW2 + i*NW + W +: W+1]};
    assign dlow[0][i*W +: W]       = spass[N][PW2 + i*NW +: W];
    assign dquo[0][i*W +: W]       = '0;
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    vmt_div_cell #(.W(W), .PW(PW2)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (dv[k]),
      .len_in   (dlen[k]),
      .rem_in   (drem[k]),
      .low_in   (dlow[k]),
      .quo_in   (dquo[k]),
      .pass_in  (dpass[k]),
      .valid    (dv[k+1]),
      .len      (dlen[k+1]),
      .rem      (drem[k+1]),
      .low      (dlow[k+1]),
      .quo      (dquo[k+1]),
      .pass     (dpass[k+1])
    );
  end

  assign e_reached = dpass[W][0];
  assign e_neg     = dpass[W][4:1];
  assign e_goal    = dpass[W][4*W+4:5];
  assign e_cur     = dpass[W][8*W+4:4*W+5];

  logic [W+1:0] qs  [4];
  logic [W+1:0] tsum[4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qs[i]   = e_neg[i] ? (~{2'b00, dquo[W][i*W +: W]} + 1'b1)
                         : {2'b00, dquo[W][i*W +: W]};
      tsum[i] = {{2{e_cur[i*W+W-1]}}, e_cur[i*W +: W]} + qs[i];
      if (e_reached) begin
        res[i] = e_goal[i*W +: W];
      end else if (tsum[i][W+1] == 1'b0 && tsum[i][W:W-1] != 2'b00) begin
        res[i] = {1'b0, {(W-1){1'b1}}};
      end else if (tsum[i][W+1] == 1'b1 && tsum[i][W:W-1] != 2'b11) begin
        res[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        res[i] = tsum[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      next_x  <= res[0];
      next_y  <= res[1];
      next_z  <= res[2];
      next_w  <= res[3];
      reached <= e_reached;
    end
  end

  `VMT_ASSERT_IMPL(a_len_nonzero, sv[N] && !spass[N][0], sroot[N] != '0, "zero length on divide path")
  `VMT_ASSERT_IMPL(a_sqrt_rem, sv[N], srem[N] <= {1'b0, sroot[N], 1'b0}, "root remainder too large")
  `VMT_ASSERT_IMPL(a_div_rem, dv[W] && !e_reached, drem[W][W+2:0] < {1'b0, dlen[W]}, "divide remainder not below length")
  `VMT_ASSERT_NEXT(a_out_load, dv[W] && en, out_valid, "finished word not loaded to output")
endmodule

@@ test/vmt_checker.sv @@
`timescale 1ns / 1ps
module vmt_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] cur_x,
  input  logic signed [31:0] cur_y,
  input  logic signed [31:0] cur_z,
  input  logic signed [31:0] cur_w,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  input  logic signed [31:0] goal_z,
  input  logic signed [31:0] goal_w,
  input  logic signed [31:0] step_max,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] next_x,
  input  logic signed [31:0] next_y,
  input  logic signed [31:0] next_z,
  input  logic signed [31:0] next_w,
  input  logic               reached,
  output int                 errors,
  output int                 pending
);
  typedef struct packed {
    logic signed [3:0][31:0] pos;
    logic                    hit;
  } move_t;

  move_t moves_due[$];

  function automatic logic [63:0] root_floor(logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic move_t predict_move(logic signed [3:0][31:0] c,
                                         logic signed [3:0][31:0] g,
                                         logic signed [31:0] st);
    move_t m;
    logic signed [33:0] d [4];
    logic [127:0] s;
    logic [127:0] st2;
    logic [63:0]  len;
    logic [127:0] q;
    logic [127:0] ad;
    logic [127:0] ast;
    logic signed [65:0] qs;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      d[i] = 34'($signed(g[i])) - 34'($signed(c[i]));
      ad = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
      s += ad * ad;
    end
    ast = st < 0 ? 128'(-34'(st)) : 128'(st);
    st2 = ast * ast;
    if (s == 0 || (st >= 0 && s <= st2)) begin
      m.pos = g;
      m.hit = 1'b1;
      return m;
    end
    len = root_floor(s);
    for (int i = 0; i < 4; i++) begin
      ad = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
      q = (ad * ast) / {64'd0, len};
      qs = ((d[i] < 0) != (st < 0)) ? -66'(q) : 66'(q);
      m.pos[i] = clamp(66'($signed(c[i])) + qs);
    end
    m.hit = 1'b0;
    return m;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    move_t e;
    move_t a;
    if (!rst) begin
      if (in_valid && in_ready)
        moves_due.push_back(predict_move({cur_w, cur_z, cur_y, cur_x},
                                         {goal_w, goal_z, goal_y, goal_x}, step_max));
      if (out_valid && out_ready) begin
        a.pos = {next_w, next_z, next_y, next_x};
        a.hit = reached;
        if (moves_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", a);
        end else begin
          e = moves_due.pop_front();
          if (e !== a) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp x=%h y=%h z=%h w=%h r=%b got x=%h y=%h z=%h w=%h r=%b",
                       e.pos[0], e.pos[1], e.pos[2], e.pos[3], e.hit,
                       a.pos[0], a.pos[1], a.pos[2], a.pos[3], a.hit);
          end
        end
      end
    end
    pending = moves_due.size();
  end
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, reached;
  logic signed [31:0] cur_x, cur_y, cur_z, cur_w;
  logic signed [31:0] goal_x, goal_y, goal_z, goal_w, step_max;
  logic signed [31:0] next_x, next_y, next_z, next_w;
  int errors, pending;
  int send_idle, recv_idle;
  bit hold_off;

  vec4_move_towards_top DUT (.*);
  vmt_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("vec4_move_towards_top regression: fail");
    $finish;
  end

  function automatic logic signed [31:0] pick();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 8)) - 4;
      3: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic signed [31:0] c[4], logic signed [31:0] g[4],
                      logic signed [31:0] s);
    while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {cur_x, cur_y, cur_z, cur_w} <= {c[0], c[1], c[2], c[3]};
    {goal_x, goal_y, goal_z, goal_w} <= {g[0], g[1], g[2], g[3]};
    step_max <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random();
    logic signed [31:0] c[4], g[4];
    logic signed [31:0] s;
    for (int i = 0; i < 4; i++) begin
      c[i] = pick();
      g[i] = $urandom_range(0, 2) == 0 ? c[i] + ($signed($urandom) >>> 20) : pick();
    end
    if ($urandom_range(0, 9) == 0) g = c;
    s = pick();
    send(c, g, s);
  endtask

  always @(posedge clk) begin
    if (hold_off) out_ready <= 0;
    else if (recv_idle > 0) out_ready <= $urandom_range(0, 99) >= recv_idle;
    else out_ready <= 1;
  end

  initial begin
    logic signed [31:0] c[4], g[4];
    rst = 1; in_valid = 0; out_ready = 0; hold_off = 0;
    send_idle = 0; recv_idle = 0;
    {cur_x, cur_y, cur_z, cur_w, goal_x, goal_y, goal_z, goal_w, step_max} = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    c = '{0, 0, 0, 0}; g = '{0, 0, 0, 0};
    send(c, g, 0);
    send(c, g, -5);
    g = '{3 << 16, 4 << 16, 0, 0};
    send(c, g, 0);
    send(c, g, 5 << 16);
    send(c, g, 1 << 16);
    send(c, g, -(1 << 16));
    send(c, g, 7);
    c = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    g = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    send(c, g, 32'sh7fffffff);
    send(c, g, 32'sh80000000);
    send(g, c, 32'sh80000000);
    send(c, g, 1);
    send(c, c, 32'sh80000000);
    c = '{32'sh7fff0000, 0, 0, 0}; g = '{32'sh7fff0001, 0, 0, 0};
    send(c, g, -32'sd100);
    send(g, c, -32'sd100);
    for (int i = 0; i < 6; i++) send_random();
    for (int p = 0; p < 4; p++) begin
      send_idle = p == 1 || p == 3 ? 83 : 0;
      recv_idle = p == 2 || p == 3 ? 83 : 0;
      if (p == 3) begin
        send_idle = 6; recv_idle = 6;
      end
      for (int i = 0; i < 440; i++) begin
        if (p == 0 && i == 100) begin
          fork
            begin
              hold_off = 1;
              repeat (300) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        if (p == 2 && i == 200) begin
          in_valid <= 0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_random();
      end
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("vec4_move_towards_top regression: pass");
    else $display("vec4_move_towards_top regression: fail");
    $finish;
  end
endmodule
